/* hw/rtl/b64e_pkg.sv */
package b64e_pkg;

   localparam int unsigned CHARS_PER_JOB = 4;

   localparam logic [6:0] PAD_CHAR = 7'h3D;   // '='

   // position within the current three-byte group
   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   // characters caused by one byte, waiting for the back end
   typedef struct packed {
      logic [CHARS_PER_JOB-1:0][6:0] chars;
      logic [1:0]                    last_idx;   // index of the final character
      logic                          msg_end;    // final character ends the message
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // sextet to standard alphabet character
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = 7'(v) + 7'd65;
      end else if (v < 6'd52) begin
         c = 7'(v) + 7'd71;
      end else if (v < 6'd62) begin
         c = 7'(v) - 7'd4;
      end else if (v == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

endpackage

/* hw/rtl/b64e_front.sv */
module b64e_front
   import b64e_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             is_final,
   output job_type          job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;

   // next state
   always_comb begin
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      if (accept) begin
         unique case (phase_ff)
            PHASE_SECOND: begin
               phase_in    = is_final ? PHASE_FIRST : PHASE_THIRD;
               leftover_in = is_final ? 4'd0 : data_byte[3:0];
            end
            PHASE_THIRD: begin
               phase_in    = PHASE_FIRST;
               leftover_in = 4'd0;
            end
            default: begin
               phase_in    = is_final ? PHASE_FIRST : PHASE_SECOND;
               leftover_in = is_final ? 4'd0 : {2'b00, data_byte[1:0]};
            end
         endcase
      end
   end

   // characters for this byte
   always_comb begin
      job.msg_end = is_final;
      job.chars   = {CHARS_PER_JOB{PAD_CHAR}};
      unique case (phase_ff)
         PHASE_SECOND: begin
            job.chars[0] = b64_char({leftover_ff[1:0], data_byte[7:4]});
            job.chars[1] = b64_char({data_byte[3:0], 2'b00});
            job.last_idx = is_final ? 2'd2 : 2'd0;
         end
         PHASE_THIRD: begin
            job.chars[0] = b64_char({leftover_ff, data_byte[7:6]});
            job.chars[1] = b64_char(data_byte[5:0]);
            job.last_idx = 2'd1;
         end
         default: begin
            job.chars[0] = b64_char(data_byte[7:2]);
            job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
            job.last_idx = is_final ? 2'd3 : 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_FIRST;
         leftover_ff <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

/* hw/rtl/b64e_queue.sv */
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/b64e_back.sv */
module b64e_back
   import b64e_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type status,
   output logic             pop,
   output logic             out_valid,
   output logic [6:0]       out_char,
   output logic             char_last,
   input  logic             out_stall
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   // output register free or being taken this cycle, and a job waiting
   assign load   = (!valid_ff || !out_stall) && !status.empty;
   assign at_end = (idx_ff == head_job.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (!valid_ff || !out_stall) begin
         valid_in = !status.empty;
      end
      if (load) begin
         char_in = head_job.chars[idx_ff];
         last_in = at_end && head_job.msg_end;
         idx_in  = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign char_last = last_ff;

endmodule

/* hw/rtl/base64_stream_encoder_top.sv */
// the first character of a byte passes through a job queue slot and then the output
//    register before it is on rsp_
// one character per cycle while rsp_stall is low and a job waits; one to four characters
//    per byte, four per three bytes in a long message, set by the single-character output register
// a byte is taken whenever the job queue has a free slot
// reset (synchronous, active high) empties the queue and output register, new group
module base64_stream_encoder_top
   import b64e_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_char_last
);

   job_type          new_job;
   job_type          head_job;
   queue_status_type q_status;
   logic             req_accept;
   logic             q_pop;

   // front end only waits for a free queue slot
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !q_status.full;

   // front: tracks group phase and leftover bits, turns each word into a job
   b64e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .is_final  (req_is_final),
      .job       (new_job)
   );

   // short job queue so front and back stall independently
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_job (new_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: steps through the head job one character per word
   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .status    (q_status),
      .pop       (q_pop),
      .out_valid (rsp_valid),
      .out_char  (rsp_out_char),
      .char_last (rsp_char_last),
      .out_stall (rsp_stall)
   );

endmodule

/* tb/sv/tb.sv */
module tb;
   import b64e_pkg::*;

   // generous bound: every byte giving four characters, each character waiting out the
   // longest receiver stall, plus the longest sender gap and the pauses to drain
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_BYTES = 430;
   localparam int unsigned TAIL_CYCLES  = 16;

   // one encoded character as it leaves the block
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } enc_char_type;

   // tracks the encoder state on its own and holds the characters still owed
   class b64_encoding_check;
      phase_type    phase;
      logic [3:0]   carry_bits;
      enc_char_type chars_due[$];
      int unsigned  errors;

      function new();
         phase      = PHASE_FIRST;
         carry_bits = 4'd0;
         errors     = 0;
      endfunction

      // standard alphabet lookup, by table rather than by ranges
      function automatic logic [6:0] alphabet_char(input logic [5:0] v);
         string abc;
         byte   c;
         abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         c   = abc.getc(int'(v));
         return c[6:0];
      endfunction

      function void owe(input logic [6:0] ch, input logic last);
         enc_char_type e;
         e.ch   = ch;
         e.last = last;
         chars_due.push_back(e);
      endfunction

      // note an accepted byte and queue the characters it completes
      function void take_byte(input logic [7:0] b, input logic fin);
         case (phase)
            PHASE_SECOND: begin
               owe(alphabet_char({carry_bits[1:0], b[7:4]}), 1'b0);
               if (fin) begin
                  owe(alphabet_char({b[3:0], 2'b00}), 1'b0);
                  owe(PAD_CHAR, 1'b1);
                  phase      = PHASE_FIRST;
                  carry_bits = 4'd0;
               end else begin
                  phase      = PHASE_THIRD;
                  carry_bits = b[3:0];
               end
            end
            PHASE_THIRD: begin
               owe(alphabet_char({carry_bits, b[7:6]}), 1'b0);
               owe(alphabet_char(b[5:0]), fin);
               phase      = PHASE_FIRST;
               carry_bits = 4'd0;
            end
            default: begin
               owe(alphabet_char(b[7:2]), 1'b0);
               if (fin) begin
                  owe(alphabet_char({b[1:0], 4'b0000}), 1'b0);
                  owe(PAD_CHAR, 1'b0);
                  owe(PAD_CHAR, 1'b1);
                  phase      = PHASE_FIRST;
                  carry_bits = 4'd0;
               end else begin
                  phase      = PHASE_SECOND;
                  carry_bits = {2'b00, b[1:0]};
               end
            end
         endcase
      endfunction

      // compare an accepted character with the oldest one owed
      function void match_char(input logic [6:0] ch, input logic last);
         enc_char_type e;
         if (chars_due.size() == 0) begin
            $display("%0t: unexpected character, got char %h last %b", $time, ch, last);
            errors++;
         end else begin
            e = chars_due.pop_front();
            if (ch !== e.ch) begin
               $display("%0t: out_char mismatch, expected %h got %h", $time, e.ch, ch);
               errors++;
            end
            if (last !== e.last) begin
               $display("%0t: char_last mismatch, expected %b got %b", $time, e.last, last);
               errors++;
            end
         end
      endfunction

      function int unsigned pending();
         return chars_due.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_char_last;

   b64_encoding_check board;

   logic [7:0]  msg_bytes[$];   // bytes of the message about to be sent
   int unsigned bytes_sent;
   logic        send_calm;      // sender stretch with no gaps
   int unsigned rsp_hold;       // cycles left before the receiver picks again
   int unsigned rsp_pick;
   int unsigned cycle_count;

   base64_stream_encoder_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_is_final  (req_is_final),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_char_last (rsp_char_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // timeout guard
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // sender gap length: mostly none or short, now and then long
   function automatic int unsigned send_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (send_calm || r < 55) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   // offer one word and hold it until the block takes it
   // called just after a rising edge; returns at the edge that accepted the word
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = send_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_is_final  <= fin;
      // values seen at the edge are the ones before it, so this is the accepting edge
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_byte(b, fin);
      bytes_sent++;
   endtask

   // send msg_bytes as one message, final flag on the last byte
   task automatic send_message();
      int unsigned i;
      send_calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < msg_bytes.size(); i++) begin
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      end
   endtask

   // sender holds off until every owed character has left
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // receiver: check what leaves, then choose the next stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         board.match_char(rsp_out_char, rsp_char_last);
      end
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_pick = $urandom_range(0, 99);
         if (rsp_pick < 8) begin
            // long stretch with no back-pressure at all
            rsp_stall <= 1'b0;
            rsp_hold  <= $urandom_range(40, 120);
         end else if (rsp_pick < 34) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(0, 2);
         end else if (rsp_pick < 40) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(5, 25);
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold  <= $urandom_range(0, 3);
         end
      end
   end

   initial begin
      int unsigned len;
      int unsigned i;
      int unsigned r;
      logic        paused;
      board      = new();
      bytes_sent = 0;
      send_calm  = 1'b0;
      rsp_hold   = 0;
      paused     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every way a message can end, extreme bytes, '+' and '/'
      msg_bytes = '{8'h00};                            // one byte, two pads
      send_message();
      msg_bytes = '{8'hFF};
      send_message();
      msg_bytes = '{8'h00, 8'hFF};                     // two bytes, one pad
      send_message();
      msg_bytes = '{8'hFF, 8'h00};
      send_message();
      msg_bytes = '{8'h00, 8'h00, 8'h00};              // full group, no pad
      send_message();
      msg_bytes = '{8'hFF, 8'hFF, 8'hFF};
      send_message();
      msg_bytes = '{8'h4D, 8'h61, 8'h6E};
      send_message();
      msg_bytes = '{8'hFB, 8'hEF, 8'hBE, 8'h0F};       // group then lone final byte
      send_message();
      msg_bytes = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h3C}; // group then two-byte tail
      send_message();

      // let everything drain once before the random part
      wait_drained();
      @(posedge clock);

      // random messages, mostly short, some long enough to span many groups
      while (bytes_sent < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            len = $urandom_range(1, 6);
         end else if (r < 90) begin
            len = $urandom_range(7, 16);
         end else begin
            len = $urandom_range(17, 40);
         end
         msg_bytes.delete();
         for (i = 0; i < len; i++) begin
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_message();
         // halfway through, hold the sender until the encoder has emptied
         if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
            paused = 1'b1;
            wait_drained();
            @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // wait for every owed character, then a little longer for strays
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
